[rtl/core/at2a_pkg.sv]
`timescale 1ns / 1ps

package at2a_pkg;

  // Defaults of the top-level parameters.
  localparam int ITERATIONS_DEF  = 16;
  localparam int ANGLE_FRAC_DEF  = 13;

  // The arctangent table has this many entries, so no more iterations than this are run.
  localparam int TAB_LEN         = 24;

  // The angle accumulator has this many fractional bits.
  localparam int ACC_FRAC        = 30;

  // Widths of the coordinates, magnitudes, normalised operands, CORDIC datapath and angle.
  localparam int IN_W            = 32;
  localparam int MAG_W           = 32;
  localparam int NORM_W          = 40;
  localparam int XY_W            = 44;
  localparam int Z_W             = 33;
  localparam int ACC_W           = 32;
  localparam int ANGLE_W         = 16;
  localparam int BAND_W          = 16;

  // Pipeline depth around the CORDIC stages.
  localparam int PRE_STAGES      = 3;
  localparam int POST_STAGES     = 2;

  // Right angle and straight angle in accumulator units.
  localparam logic [ACC_W-1:0] HALF_PI_ACC = 32'd1686629713;
  localparam logic [ACC_W-1:0] PI_ACC      = 32'd3373259426;

  localparam logic [BAND_W-1:0] ZERO_BAND_RST = 16'd1;

  // Quadrant and special-case flags that travel alongside each transaction.
  typedef struct packed {
    logic xneg;
    logic yneg;
    logic yzero;
    logic band;
  } side_t;

  // atan(2^-idx) scaled by 2^30, truncated.
  function automatic logic [ACC_W-1:0] atan_entry(input int idx);
    logic [ACC_W-1:0] r;
    case (idx)
      0:       r = 32'h3243F6A8;
      1:       r = 32'h1DAC6705;
      2:       r = 32'h0FADBAFC;
      3:       r = 32'h07F56EA6;
      4:       r = 32'h03FEAB76;
      5:       r = 32'h01FFD55B;
      6:       r = 32'h00FFFAAA;
      7:       r = 32'h007FFF55;
      8:       r = 32'h003FFFEA;
      9:       r = 32'h001FFFFD;
      10:      r = 32'h000FFFFF;
      11:      r = 32'h0007FFFF;
      12:      r = 32'h0003FFFF;
      13:      r = 32'h0001FFFF;
      14:      r = 32'h0000FFFF;
      15:      r = 32'h00007FFF;
      16:      r = 32'h00003FFF;
      17:      r = 32'h00001FFF;
      18:      r = 32'h00000FFF;
      19:      r = 32'h000007FF;
      20:      r = 32'h000003FF;
      21:      r = 32'h000001FF;
      22:      r = 32'h000000FF;
      23:      r = 32'h0000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/atan2_angle.sv]
`timescale 1ns / 1ps

// Four-quadrant arctangent of a signed 32-bit coordinate pair (y_value, x_value), returned
// on angle in radians scaled by 2^ANGLE_FRAC_BITS (pi is 25736 at the default of 13).
// A transaction is taken at every rising edge where start is high and busy is low; busy is
// high only while rst is asserted, so one transaction per clock is sustained indefinitely.
// Each result appears on angle for exactly one cycle with done high, when its transaction
// has passed through the pipeline; the receiver cannot stall the block and must capture
// the result in that cycle. The pipeline is the CORDIC chain, one vectoring iteration per
// pipeline stage, with three stages of magnitude and normalising-shift logic ahead of it
// and two stages of quadrant folding and rounding behind it. Results leave in the order
// their transactions arrived.
// When |x| is strictly below the zero_band register, the result is +pi/2, -pi/2 or zero
// according to the sign of y; when y is zero outside that band, it is pi for negative x and
// zero otherwise. zero_band resets to 1 and is written with cfg_write and cfg_data; write it
// only when no transaction is in flight. A zero band of zero treats no x as zero.

module atan2_angle
  import at2a_pkg::*;
#(
  parameter int ITERATIONS      = ITERATIONS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [IN_W-1:0]    y_value,
  input  logic signed [IN_W-1:0]    x_value,
  input  logic                      cfg_write,
  input  logic [BAND_W-1:0]         cfg_data,
  output logic                      done,
  output logic signed [ANGLE_W-1:0] angle
);

  // Iterations beyond the length of the arctangent table add nothing.
  localparam int N   = (ITERATIONS > TAB_LEN) ? TAB_LEN : ITERATIONS;
  localparam int LAT = PRE_STAGES + N + POST_STAGES;

  // Nothing is taken while the pipeline is being cleared by reset.
  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  // Zero band register.
  logic [BAND_W-1:0] zero_band;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_band <= ZERO_BAND_RST;
    end else if (cfg_write) begin
      zero_band <= cfg_data;
    end
  end

  // Magnitudes, flags and normalisation, so that the larger magnitude has its leading
  // one at the top of the 40-bit operand before the iterations start.
  logic              pre_valid;
  logic [NORM_W-1:0] x_norm, y_norm;
  side_t             pre_side;

  at2a_pre u_pre (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .y_value   (y_value),
    .x_value   (x_value),
    .zero_band (zero_band),
    .out_valid (pre_valid),
    .x_norm    (x_norm),
    .y_norm    (y_norm),
    .side      (pre_side)
  );

  // CORDIC vectoring chain: stage i rotates by atan(2^-i) towards the x axis and keeps
  // the accumulated angle. The quadrant flags ride along unchanged.
  logic                   cv [0:N];
  logic signed [XY_W-1:0] cx [0:N];
  logic signed [XY_W-1:0] cy [0:N];
  logic signed [Z_W-1:0]  cz [0:N];
  side_t                  cs [0:N];

  assign cv[0] = pre_valid;
  assign cx[0] = $signed({{(XY_W-NORM_W){1'b0}}, x_norm});
  assign cy[0] = $signed({{(XY_W-NORM_W){1'b0}}, y_norm});
  assign cz[0] = '0;
  assign cs[0] = pre_side;

  for (genvar i = 0; i < N; i++) begin : g_iter
    at2a_stage #(
      .IDX (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .x_in      (cx[i]),
      .y_in      (cy[i]),
      .z_in      (cz[i]),
      .side_in   (cs[i]),
      .out_valid (cv[i+1]),
      .x_out     (cx[i+1]),
      .y_out     (cy[i+1]),
      .z_out     (cz[i+1]),
      .side_out  (cs[i+1])
    );
  end

  // Quadrant folding, rounding and selection of the special-case results. The final x and
  // y of the chain are not needed, only the angle.
  at2a_post #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_post (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cv[N]),
    .z_in     (cz[N]),
    .side_in  (cs[N]),
    .done     (done),
    .angle    (angle)
  );

  // Every transaction taken produces its result once it has passed through the pipeline.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("transaction taken but no result after the pipeline latency");

  // No result appears without a transaction taken one latency earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result strobe without a matching transaction");

  // Reset empties the whole pipeline, so the strobe is low in the cycle after it.
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe straight after reset");

endmodule

[rtl/core/at2a_pre.sv]
`timescale 1ns / 1ps

module at2a_pre
  import at2a_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [IN_W-1:0]   y_value,
  input  logic signed [IN_W-1:0]   x_value,
  input  logic [BAND_W-1:0]        zero_band,
  output logic                     out_valid,
  output logic [NORM_W-1:0]        x_norm,
  output logic [NORM_W-1:0]        y_norm,
  output side_t                    side
);

  typedef struct packed {
    logic [NORM_W-1:0] m;
    logic [NORM_W-1:0] x;
    logic [NORM_W-1:0] y;
  } norm_t;

  // Shifts all three left by k when the top k bits of the larger magnitude are clear.
  function automatic norm_t shift_step(input norm_t a, input int k);
    norm_t r;
    r = a;
    if ((a.m >> (NORM_W - k)) == '0) begin
      r.m = a.m << k;
      r.x = a.x << k;
      r.y = a.y << k;
    end
    return r;
  endfunction

  // Stage one: magnitudes, larger magnitude and flags.
  logic              v1;
  logic [MAG_W-1:0]  ax1, ay1, m1;
  side_t             side1;

  logic [MAG_W-1:0]  ax, ay;
  side_t             side_next;

  always_comb begin
    ax = x_value[IN_W-1] ? MAG_W'(~x_value + 1'b1) : MAG_W'(x_value);
    ay = y_value[IN_W-1] ? MAG_W'(~y_value + 1'b1) : MAG_W'(y_value);
    side_next.xneg  = x_value[IN_W-1];
    side_next.yneg  = y_value[IN_W-1];
    side_next.yzero = (y_value == '0);
    side_next.band  = (ax < {{(MAG_W-BAND_W){1'b0}}, zero_band});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    ax1   <= ax;
    ay1   <= ay;
    m1    <= (ax > ay) ? ax : ay;
    side1 <= side_next;
  end

  // Stage two: coarse part of the normalising shift.
  logic   v2;
  norm_t  n2;
  side_t  side2;
  norm_t  n1, n2_next;

  always_comb begin
    n1.m    = {{(NORM_W-MAG_W){1'b0}}, m1};
    n1.x    = {{(NORM_W-MAG_W){1'b0}}, ax1};
    n1.y    = {{(NORM_W-MAG_W){1'b0}}, ay1};
    n2_next = shift_step(shift_step(shift_step(n1, 32), 16), 8);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    n2    <= n2_next;
    side2 <= side1;
  end

  // Stage three: fine part of the normalising shift.
  norm_t n3_next;

  always_comb begin
    n3_next = shift_step(shift_step(shift_step(n2, 4), 2), 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2;
    end
    x_norm <= n3_next.x;
    y_norm <= n3_next.y;
    side   <= side2;
  end

endmodule

[rtl/core/at2a_stage.sv]
`timescale 1ns / 1ps

module at2a_stage
  import at2a_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [XY_W-1:0]  x_in,
  input  logic signed [XY_W-1:0]  y_in,
  input  logic signed [Z_W-1:0]   z_in,
  input  side_t                   side_in,
  output logic                    out_valid,
  output logic signed [XY_W-1:0]  x_out,
  output logic signed [XY_W-1:0]  y_out,
  output logic signed [Z_W-1:0]   z_out,
  output side_t                   side_out
);

  localparam logic signed [Z_W-1:0] ANG = Z_W'(atan_entry(IDX));

  logic signed [XY_W-1:0] dx, dy;
  logic signed [XY_W-1:0] x_next, y_next;
  logic signed [Z_W-1:0]  z_next;
  logic                   rot_down;

  always_comb begin
    dx       = y_in >>> IDX;
    dy       = x_in >>> IDX;
    rot_down = !y_in[XY_W-1] && (y_in != '0);
    if (rot_down) begin
      x_next = x_in + dx;
      y_next = y_in - dy;
      z_next = z_in + ANG;
    end else begin
      x_next = x_in - dx;
      y_next = y_in + dy;
      z_next = z_in - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    x_out    <= x_next;
    y_out    <= y_next;
    z_out    <= z_next;
    side_out <= side_in;
  end

endmodule

[rtl/core/at2a_post.sv]
`timescale 1ns / 1ps

module at2a_post
  import at2a_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic signed [Z_W-1:0]     z_in,
  input  side_t                     side_in,
  output logic                      done,
  output logic signed [ANGLE_W-1:0] angle
);

  localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic [ACC_W:0] RND = (ACC_W+1)'(1) << (SH - 1);
  localparam logic [ANGLE_W-1:0] HP_R =
    ANGLE_W'(({1'b0, HALF_PI_ACC} + RND) >> SH);
  localparam logic [ANGLE_W-1:0] PI_R =
    ANGLE_W'(({1'b0, PI_ACC} + RND) >> SH);

  // Stage one: clamp to the first quadrant and fold into the second when x is negative.
  logic             va;
  logic [ACC_W-1:0] mag_a;
  side_t            side_a;
  logic [ACC_W-1:0] clamp, mag_next;

  always_comb begin
    if (z_in[Z_W-1]) begin
      clamp = '0;
    end else if (z_in > $signed({1'b0, HALF_PI_ACC})) begin
      clamp = HALF_PI_ACC;
    end else begin
      clamp = z_in[ACC_W-1:0];
    end
    mag_next = side_in.xneg ? (PI_ACC - clamp) : clamp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= in_valid;
    end
    mag_a  <= mag_next;
    side_a <= side_in;
  end

  // Stage two: round half up, apply the sign of y, and pick the special cases.
  logic [ACC_W:0]     sum;
  logic [ANGLE_W-1:0] rounded, angle_next;

  always_comb begin
    sum     = {1'b0, mag_a} + RND;
    rounded = ANGLE_W'(sum >> SH);
    if (side_a.band) begin
      if (side_a.yzero) begin
        angle_next = '0;
      end else if (side_a.yneg) begin
        angle_next = ~HP_R + 1'b1;
      end else begin
        angle_next = HP_R;
      end
    end else if (side_a.yzero) begin
      angle_next = side_a.xneg ? PI_R : '0;
    end else begin
      angle_next = side_a.yneg ? (~rounded + 1'b1) : rounded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= va;
    end
    angle <= angle_next;
  end

endmodule
